// ----- hw/rtl/ard_pkg.sv -----
// ============================================================================
// Attitude record deframer package
// Shared constants, types and the label character table.
// ============================================================================
`default_nettype none

package ard_pkg;

    localparam int LABEL_BYTES   = 20;
    localparam int SYNC_LEN      = 9;
    localparam int ATT_BODY_LEN  = 110;
    localparam int DAYS_POS      = 72;
    localparam int MILLIS_POS    = 74;
    localparam int ID_START      = 106;
    localparam int ID_SPAN       = 24;
    localparam int GROUP_BYTES   = 6;

    localparam int POS_W   = 17;
    localparam int MATCH_W = 4;
    localparam int SUM_W   = 33;

    localparam logic [63:0] NORM_K  = 64'd32767 * 64'd32767;
    localparam logic [SUM_W-1:0] NORM_LO = SUM_W'((NORM_K * 64'd199 + 64'd199) / 64'd200);
    localparam logic [SUM_W-1:0] NORM_HI = SUM_W'((NORM_K * 64'd399 + 64'd199) / 64'd200);

    typedef enum logic [1:0] {
        STAT_GOOD     = 2'd0,
        STAT_BAD_LEN  = 2'd1,
        STAT_BAD_ID   = 2'd2,
        STAT_BAD_NORM = 2'd3
    } rec_status_t;

    typedef struct packed {
        logic              len_ok;
        logic              ident_err;
        logic [15:0]       days;
        logic [31:0]       millis;
        logic signed [15:0] q0;
        logic signed [15:0] q1;
        logic signed [15:0] q2;
        logic signed [15:0] q3;
    } rec_t;

    typedef struct packed {
        rec_status_t       status;
        logic [15:0]       days;
        logic [31:0]       millis;
        logic signed [15:0] q_scalar;
        logic signed [15:0] q_x;
        logic signed [15:0] q_y;
        logic signed [15:0] q_z;
    } res_t;

    function automatic logic [7:0] sync_char(input logic [MATCH_W-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            4'd0:    c = 8'h4E; // N
            4'd1:    c = 8'h4A; // J
            4'd2:    c = 8'h50; // P
            4'd3:    c = 8'h4C; // L
            4'd4:    c = 8'h32; // 2
            4'd5:    c = 8'h49; // I
            4'd6:    c = 8'h30; // 0
            4'd7:    c = 8'h30; // 0
            4'd8:    c = 8'h43; // C
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ident_char(input logic [1:0] grp, input logic [2:0] k);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            3'd0:    c = 8'h08;
            3'd1:    c = 8'h01;
            3'd2:    c = 8'h03;
            3'd3:    c = 8'hE9 + {6'd0, grp};
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/attitude_record_deframer.sv -----
// ============================================================================
// Attitude record deframer
// Hunts for the record label in a byte stream, parses the label and body,
// and emits one status item per record.
// ============================================================================
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | data_byte
//  out     | out_valid/out_stall | record_status, event_days, event_millis,
//          |                     | quat_scalar, quat_x, quat_y, quat_z
//
//  One byte per cycle while in_stall is low. Each status item passes
//  through a two-stage pipe that squares the final quaternion word and
//  checks the norm, and then through the output register.
//  rst_n clears the parser, the pipe and the output register.
//  in_stall rises only while a finished item waits in the hold register behind a full output.
// ============================================================================
`default_nettype none

module attitude_record_deframer #(
    parameter int LABEL_BYTES = ard_pkg::LABEL_BYTES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              record_status,
    output logic [15:0]             event_days,
    output logic [31:0]             event_millis,
    output logic signed [15:0]      quat_scalar,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z
);

    localparam int POS_W   = ard_pkg::POS_W;
    localparam int MATCH_W = ard_pkg::MATCH_W;
    localparam int SUM_W   = ard_pkg::SUM_W;
    localparam logic [POS_W-1:0] LEN_HI_POS = POS_W'(LABEL_BYTES - 2);
    localparam logic [POS_W-1:0] LEN_LO_POS = POS_W'(LABEL_BYTES - 1);
    localparam logic [POS_W-1:0] BODY_POS   = POS_W'(LABEL_BYTES);
    localparam logic [POS_W-1:0] ID_POS     = POS_W'(ard_pkg::ID_START);
    localparam logic [POS_W-1:0] ID_END     = POS_W'(ard_pkg::ID_START + ard_pkg::ID_SPAN);
    localparam logic [POS_W-1:0] DAYS_POS   = POS_W'(ard_pkg::DAYS_POS);
    localparam logic [POS_W-1:0] MILLIS_POS = POS_W'(ard_pkg::MILLIS_POS);
    localparam logic [MATCH_W-1:0] SYNC_DONE = MATCH_W'(ard_pkg::SYNC_LEN);
    localparam logic [15:0] ATT_LEN = 16'(ard_pkg::ATT_BODY_LEN);

    // parser state
    logic [MATCH_W-1:0]  match_reg, match_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [15:0]         blen_reg, blen_next;
    logic                ident_reg, ident_next, ident_upd;
    logic [15:0]         days_reg, days_next;
    logic [31:0]         millis_reg, millis_next;
    logic signed [15:0]  quat_reg [4];
    logic signed [15:0]  quat_next [4];
    logic [7:0]          hold_reg, hold_next;

    // squaring and accumulation
    logic signed [15:0]  sq_word_reg, sq_word_next;
    logic                sq_pend_reg, sq_pend_next;
    logic [31:0]         sq_reg;
    logic                sq_vld_reg;
    logic signed [31:0]  sq_full;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [SUM_W-1:0]    total;

    // result pipe
    logic                emit;
    ard_pkg::rec_t       rec_new;
    logic                e1_valid_reg, e2_valid_reg;
    ard_pkg::rec_t       e1_reg, e2_reg;
    ard_pkg::res_t       res_new;
    logic                hold_valid_reg, hold_valid_next;
    ard_pkg::res_t       hold_res_reg, hold_res_next;
    logic                out_valid_reg, out_valid_next;
    ard_pkg::res_t       out_res_reg, out_res_next;
    logic                out_take;

    logic                accept;
    logic [4:0]          rel;
    logic [1:0]          grp;
    logic [2:0]          kk;

    assign in_stall = hold_valid_reg;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        rel = 5'(pos_reg - ID_POS);
        if (rel >= 5'd18)
            grp = 2'd3;
        else if (rel >= 5'd12)
            grp = 2'd2;
        else if (rel >= 5'd6)
            grp = 2'd1;
        else
            grp = 2'd0;
        kk = 3'(rel - 5'(grp) * 5'(ard_pkg::GROUP_BYTES));
    end

    always_comb
    begin
        match_next   = match_reg;
        pos_next     = pos_reg;
        blen_next    = blen_reg;
        ident_upd    = ident_reg;
        days_next    = days_reg;
        millis_next  = millis_reg;
        quat_next    = quat_reg;
        hold_next    = hold_reg;
        sq_word_next = sq_word_reg;
        sq_pend_next = 1'b0;
        emit         = 1'b0;

        if (accept) begin
            if (match_reg != SYNC_DONE) begin
                if (data_byte == ard_pkg::sync_char(match_reg)) begin
                    match_next = match_reg + 1'b1;
                    if (match_reg + 1'b1 == SYNC_DONE) begin
                        pos_next  = POS_W'(ard_pkg::SYNC_LEN);
                        ident_upd = 1'b0;
                    end
                end else begin
                    match_next = (data_byte == ard_pkg::sync_char('0)) ? MATCH_W'(1) : '0;
                end
            end else begin
                if (pos_reg == LEN_HI_POS) begin
                    hold_next = data_byte;
                end else if (pos_reg == LEN_LO_POS) begin
                    blen_next = {hold_reg, data_byte};
                end else if (pos_reg >= BODY_POS && blen_reg == ATT_LEN) begin
                    if (pos_reg == DAYS_POS || pos_reg == DAYS_POS + 1'b1) begin
                        days_next = {days_reg[7:0], data_byte};
                    end else if (pos_reg >= MILLIS_POS && pos_reg <= MILLIS_POS + 3'd3) begin
                        millis_next = {millis_reg[23:0], data_byte};
                    end else if (pos_reg >= ID_POS && pos_reg < ID_END) begin
                        if (kk < 3'd4) begin
                            if (data_byte != ard_pkg::ident_char(grp, kk))
                                ident_upd = 1'b1;
                        end else if (kk == 3'd4) begin
                            hold_next = data_byte;
                        end else begin
                            quat_next[grp] = {hold_reg, data_byte};
                            sq_word_next   = {hold_reg, data_byte};
                            sq_pend_next   = 1'b1;
                        end
                    end
                end

                if (pos_reg >= LEN_HI_POS + 1'b1 &&
                    pos_reg == LEN_LO_POS + {1'b0, blen_next}) begin
                    emit       = 1'b1;
                    match_next = '0;
                    pos_next   = '0;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
        ident_next = emit ? 1'b0 : ident_upd;
    end

    always_comb
    begin
        rec_new.len_ok    = (blen_next == ATT_LEN);
        rec_new.ident_err = ident_upd;
        rec_new.days      = days_next;
        rec_new.millis    = millis_next;
        rec_new.q0        = quat_next[0];
        rec_new.q1        = quat_next[1];
        rec_new.q2        = quat_next[2];
        rec_new.q3        = quat_next[3];
        if (!rec_new.len_ok) begin
            rec_new.days   = '0;
            rec_new.millis = '0;
            rec_new.q0     = '0;
            rec_new.q1     = '0;
            rec_new.q2     = '0;
            rec_new.q3     = '0;
        end
    end

    assign sq_full = sq_word_reg * sq_word_reg;
    assign total   = acc_reg + (sq_vld_reg ? {1'b0, sq_reg} : '0);

    always_comb
    begin
        if (e2_valid_reg)
            acc_next = '0;
        else if (sq_vld_reg)
            acc_next = total;
        else
            acc_next = acc_reg;
    end

    always_comb
    begin
        res_new.days     = e2_reg.days;
        res_new.millis   = e2_reg.millis;
        res_new.q_scalar = e2_reg.q3;
        res_new.q_x      = e2_reg.q0;
        res_new.q_y      = e2_reg.q1;
        res_new.q_z      = e2_reg.q2;
        priority if (!e2_reg.len_ok)
            res_new.status = ard_pkg::STAT_BAD_LEN;
        else if (e2_reg.ident_err)
            res_new.status = ard_pkg::STAT_BAD_ID;
        else if (total >= ard_pkg::NORM_LO && total < ard_pkg::NORM_HI)
            res_new.status = ard_pkg::STAT_GOOD;
        else
            res_new.status = ard_pkg::STAT_BAD_NORM;
    end

    assign out_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_res_next   = hold_res_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        if (out_take) begin
            out_valid_next = hold_valid_reg || e2_valid_reg;
            if (hold_valid_reg) begin
                out_res_next    = hold_res_reg;
                hold_valid_next = e2_valid_reg;
                hold_res_next   = res_new;
            end else if (e2_valid_reg) begin
                out_res_next = res_new;
            end
        end else if (e2_valid_reg) begin
            hold_valid_next = 1'b1;
            hold_res_next   = res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            match_reg      <= '0;
            pos_reg        <= '0;
            blen_reg       <= '0;
            ident_reg      <= 1'b0;
            days_reg       <= '0;
            millis_reg     <= '0;
            quat_reg       <= '{default: '0};
            hold_reg       <= '0;
            sq_pend_reg    <= 1'b0;
            sq_vld_reg     <= 1'b0;
            acc_reg        <= '0;
            e1_valid_reg   <= 1'b0;
            e2_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            match_reg      <= match_next;
            pos_reg        <= pos_next;
            blen_reg       <= blen_next;
            ident_reg      <= ident_next;
            days_reg       <= days_next;
            millis_reg     <= millis_next;
            quat_reg       <= quat_next;
            hold_reg       <= hold_next;
            sq_pend_reg    <= sq_pend_next;
            sq_vld_reg     <= sq_pend_reg;
            acc_reg        <= acc_next;
            e1_valid_reg   <= emit;
            e2_valid_reg   <= e1_valid_reg;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_word_reg  <= sq_word_next;
        sq_reg       <= 32'(unsigned'(sq_full));
        e1_reg       <= rec_new;
        e2_reg       <= e1_reg;
        hold_res_reg <= hold_res_next;
        out_res_reg  <= out_res_next;
    end

    assign out_valid     = out_valid_reg;
    assign record_status = out_res_reg.status;
    assign event_days    = out_res_reg.days;
    assign event_millis  = out_res_reg.millis;
    assign quat_scalar   = out_res_reg.q_scalar;
    assign quat_x        = out_res_reg.q_x;
    assign quat_y        = out_res_reg.q_y;
    assign quat_z        = out_res_reg.q_z;

endmodule

`default_nettype wire

// ----- tb/attitude_record_deframer_tb.sv -----
// ============================================================================
// Attitude record deframer testbench
// Feeds byte streams of framed records, with noise and broken labels between
// them, through the deframer. Every accepted byte runs through a local
// deframer model. Each status item is checked field by field against the
// oldest queued prediction. A directed record table comes first, then random
// records, under several sender-gap and receiver-stall mixes.
// ============================================================================
`timescale 1ns / 1ps

module attitude_record_deframer_tb;
    import ard_pkg::*;

    localparam logic [7:0] LABEL_TEXT [SYNC_LEN] = '{
        8'h4E, 8'h4A, 8'h50, 8'h4C, 8'h32, 8'h49, 8'h30, 8'h30, 8'h43  // NJPL2I00C
    };
    localparam longint QUAT_FULL_SQ = 64'd32767 * 64'd32767;
    localparam int     NUM_DIRECTED = 17;
    localparam int     RANDOM_BYTES = 1400;

    typedef enum int {
        PFX_NONE,
        PFX_RESTART_N,
        PFX_NO_C,
        PFX_NOISE,
        PFX_BROKEN
    } prefix_t;

    // q is packed as {scalar, z, y, x}
    typedef struct {
        prefix_t           prefix;
        logic [15:0]       len;
        logic [15:0]       days;
        logic [31:0]       millis;
        logic [3:0][15:0]  q;
        int                bad_id;
        bit                typed;
        rec_status_t       typed_status;
    } rec_spec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         record_status;
    logic [15:0]        event_days;
    logic [31:0]        event_millis;
    logic signed [15:0] quat_scalar;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    attitude_record_deframer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .record_status (record_status),
        .event_days    (event_days),
        .event_millis  (event_millis),
        .quat_scalar   (quat_scalar),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z)
    );

    always #5 clk = ~clk;

    // deframer model state
    logic [3:0]  hunt_cnt = '0;
    logic [16:0] rec_pos = '0;
    logic [15:0] rec_len = '0;
    bit          id_fault = 1'b0;
    logic [15:0] day_cnt = '0;
    logic [31:0] ms_cnt = '0;
    logic [15:0] qw [4] = '{default: '0};
    logic [7:0]  hi_hold = '0;

    res_t        status_q [$];
    int          errors = 0;
    int          framed_bytes = 0;
    int          records_pushed = 0;
    int          status_seen [4] = '{default: 0};
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          typed_armed = 1'b0;
    res_t        typed_res;

    rec_spec_t   directed_recs [NUM_DIRECTED];

    task automatic deframe_byte(input logic [7:0] b, output bit done, output res_t r);
        int     p;
        int     rel;
        int     grp;
        int     k;
        logic [7:0] want;
        longint sum;
        longint v;
        done = 1'b0;
        r = '0;
        if (hunt_cnt < SYNC_LEN) begin
            if (b == LABEL_TEXT[hunt_cnt]) begin
                hunt_cnt++;
                if (hunt_cnt == SYNC_LEN) begin
                    rec_pos = SYNC_LEN;
                    id_fault = 1'b0;
                end
            end else begin
                hunt_cnt = (b == LABEL_TEXT[0]) ? 4'd1 : 4'd0;
            end
            return;
        end
        p = int'(rec_pos);
        if (p == LABEL_BYTES - 2) begin
            hi_hold = b;
        end else if (p == LABEL_BYTES - 1) begin
            rec_len = {hi_hold, b};
        end else if (p >= LABEL_BYTES && rec_len == ATT_BODY_LEN) begin
            if (p == DAYS_POS || p == DAYS_POS + 1) begin
                day_cnt = {day_cnt[7:0], b};
            end else if (p >= MILLIS_POS && p <= MILLIS_POS + 3) begin
                ms_cnt = {ms_cnt[23:0], b};
            end else if (p >= ID_START && p < ID_START + ID_SPAN) begin
                rel = p - ID_START;
                grp = rel / GROUP_BYTES;
                k = rel % GROUP_BYTES;
                if (k < 4) begin
                    want = (k == 0) ? 8'h08 : (k == 1) ? 8'h01 : (k == 2) ? 8'h03 :
                           8'(8'hE9 + grp);
                    if (b != want)
                        id_fault = 1'b1;
                end else if (k == 4) begin
                    hi_hold = b;
                end else begin
                    qw[grp] = {hi_hold, b};
                end
            end
        end
        if (p >= LABEL_BYTES - 1 && p == LABEL_BYTES - 1 + int'(rec_len)) begin
            done = 1'b1;
            if (rec_len != ATT_BODY_LEN) begin
                r.status = STAT_BAD_LEN;
            end else begin
                if (id_fault) begin
                    r.status = STAT_BAD_ID;
                end else begin
                    sum = 0;
                    for (int i = 0; i < 4; i++) begin
                        v = longint'($signed(qw[i]));
                        sum += v * v;
                    end
                    r.status = (200 * sum >= 199 * QUAT_FULL_SQ &&
                                200 * sum < 399 * QUAT_FULL_SQ) ? STAT_GOOD : STAT_BAD_NORM;
                end
                r.days = day_cnt;
                r.millis = ms_cnt;
                r.q_x = qw[0];
                r.q_y = qw[1];
                r.q_z = qw[2];
                r.q_scalar = qw[3];
            end
            hunt_cnt = '0;
            rec_pos = '0;
            id_fault = 1'b0;
        end else begin
            rec_pos = 17'(p + 1);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        bit   done;
        res_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (hunt_cnt == SYNC_LEN)
            framed_bytes++;
        deframe_byte(b, done, r);
        if (done) begin
            if (typed_armed) begin
                r = typed_res;
                typed_armed = 1'b0;
            end
            status_q.push_back(r);
            status_seen[r.status]++;
            records_pushed++;
        end
    endtask

    function automatic logic [7:0] record_byte(rec_spec_t s, int p);
        int rel;
        int grp;
        int k;
        logic [7:0] b;
        b = 8'($urandom);
        if (p < SYNC_LEN) begin
            b = LABEL_TEXT[p];
        end else if (p == LABEL_BYTES - 2) begin
            b = s.len[15:8];
        end else if (p == LABEL_BYTES - 1) begin
            b = s.len[7:0];
        end else if (p >= LABEL_BYTES && s.len == ATT_BODY_LEN) begin
            if (p == DAYS_POS || p == DAYS_POS + 1) begin
                b = s.days[8 * (DAYS_POS + 1 - p) +: 8];
            end else if (p >= MILLIS_POS && p <= MILLIS_POS + 3) begin
                b = s.millis[8 * (MILLIS_POS + 3 - p) +: 8];
            end else if (p >= ID_START && p < ID_START + ID_SPAN) begin
                rel = p - ID_START;
                grp = rel / GROUP_BYTES;
                k = rel % GROUP_BYTES;
                case (k)
                    0: b = 8'h08;
                    1: b = 8'h01;
                    2: b = 8'h03;
                    3: b = 8'(8'hE9 + grp);
                    4: b = s.q[grp][15:8];
                    default: b = s.q[grp][7:0];
                endcase
                if (rel == s.bad_id)
                    b = b ^ 8'($urandom_range(1, 255));
            end
        end
        return b;
    endfunction

    task automatic send_record(rec_spec_t s);
        int n;
        logic [7:0] b;
        case (s.prefix)
            PFX_RESTART_N: begin
                for (int i = 0; i < 3; i++)
                    send_byte(LABEL_TEXT[i]);
            end
            PFX_NO_C: begin
                for (int i = 0; i < SYNC_LEN - 1; i++)
                    send_byte(LABEL_TEXT[i]);
                send_byte(8'h58);
            end
            PFX_NOISE: begin
                n = $urandom_range(1, 12);
                repeat (n)
                    send_byte(8'($urandom));
            end
            PFX_BROKEN: begin
                n = $urandom_range(1, SYNC_LEN - 1);
                for (int i = 0; i < n; i++)
                    send_byte(LABEL_TEXT[i]);
                do
                    b = 8'($urandom);
                while (b == LABEL_TEXT[n]);
                send_byte(b);
            end
            default: ;
        endcase
        if (s.typed) begin
            typed_res = '0;
            typed_res.status = s.typed_status;
            if (s.typed_status != STAT_BAD_LEN) begin
                typed_res.days = s.days;
                typed_res.millis = s.millis;
                typed_res.q_x = s.q[0];
                typed_res.q_y = s.q[1];
                typed_res.q_z = s.q[2];
                typed_res.q_scalar = s.q[3];
            end
            typed_armed = 1'b1;
        end
        for (int p = 0; p <= LABEL_BYTES - 1 + int'(s.len); p++)
            send_byte(record_byte(s, p));
    endtask

    function automatic rec_spec_t random_record();
        rec_spec_t s;
        int        pick;
        int        a;
        int        b;
        int        c;
        int        sc;
        real       lim;
        s.typed = 1'b0;
        s.typed_status = STAT_GOOD;
        s.bad_id = -1;
        s.days = 16'($urandom);
        s.millis = $urandom;
        s.q = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        s.prefix = (pick < 70) ? PFX_NONE : (pick < 85) ? PFX_NOISE : PFX_BROKEN;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            s.len = 16'(ATT_BODY_LEN);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                // near unit norm, spread across the lower tolerance edge
                a = int'($urandom_range(0, 36000)) - 18000;
                b = int'($urandom_range(0, 36000)) - 18000;
                c = int'($urandom_range(0, 36000)) - 18000;
                lim = (0.99 + 0.43 * $urandom_range(0, 1000) / 1000.0) * 1073676289.0
                      - real'(a) * a - real'(b) * b - real'(c) * c;
                sc = (lim > 0.0) ? $rtoi($sqrt(lim)) : 0;
                if (sc > 32767)
                    sc = 32767;
                if ($urandom_range(0, 1))
                    sc = -sc;
                s.q = {16'(sc), 16'(c), 16'(b), 16'(a)};
            end
            if ($urandom_range(0, 99) < 12)
                s.bad_id = GROUP_BYTES * $urandom_range(0, 3) + $urandom_range(0, 3);
        end else if (pick < 92) begin
            s.len = 16'($urandom_range(0, 30));
        end else begin
            case ($urandom_range(0, 2))
                0: s.len = 16'(ATT_BODY_LEN - 1);
                1: s.len = 16'(ATT_BODY_LEN + 1);
                default: s.len = 16'($urandom_range(100, 300));
            endcase
        end
        return s;
    endfunction

    task automatic set_phase(int ph);
        case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 53; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 53; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : status_monitor
        res_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected status item: expected none, got status %0d",
                         $time, record_status);
            end else begin
                want = status_q.pop_front();
                check_field("record_status", 32'(want.status), 32'(record_status));
                check_field("event_days", 32'(want.days), 32'(event_days));
                check_field("event_millis", want.millis, event_millis);
                check_field("quat_scalar", 32'(want.q_scalar), 32'(quat_scalar));
                check_field("quat_x", 32'(want.q_x), 32'(quat_x));
                check_field("quat_y", 32'(want.q_y), 32'(quat_y));
                check_field("quat_z", 32'(want.q_z), 32'(quat_z));
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d status items still outstanding", status_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        // prefix, len, days, millis, quat {s, z, y, x}, bad ident byte, typed, status
        directed_recs = '{
            '{PFX_RESTART_N, 16'd0, 16'd0, 32'd0, 64'd0, -1, 1'b1, STAT_BAD_LEN},
            '{PFX_NO_C, 16'd1, 16'd0, 32'd0, 64'd0, -1, 1'b1, STAT_BAD_LEN},
            '{PFX_NONE, 16'd109, 16'd0, 32'd0, 64'd0, -1, 1'b1, STAT_BAD_LEN},
            '{PFX_NONE, 16'd111, 16'd0, 32'd0, 64'd0, -1, 1'b1, STAT_BAD_LEN},
            '{PFX_NONE, 16'd110, 16'd0, 32'd0, {16'h7FFF, 16'h0, 16'h0, 16'h0},
              -1, 1'b1, STAT_GOOD},
            '{PFX_NONE, 16'd110, 16'hFFFF, 32'hFFFF_FFFF, 64'd0, -1, 1'b1, STAT_BAD_NORM},
            '{PFX_NONE, 16'd110, 16'h1234, 32'h89AB_CDEF, {4{16'h8000}},
              -1, 1'b1, STAT_BAD_NORM},
            '{PFX_NONE, 16'd110, 16'h0001, 32'h0000_0001, {4{16'h7FFF}},
              -1, 1'b1, STAT_BAD_NORM},
            '{PFX_NONE, 16'd110, 16'h00FF, 32'h0102_0304, {4{16'h4000}},
              0, 1'b1, STAT_BAD_ID},
            '{PFX_NONE, 16'd110, 16'hFF00, 32'hFEDC_BA98, {16'h7FFF, 16'h0, 16'h0, 16'h0},
              21, 1'b1, STAT_BAD_ID},
            '{PFX_NONE, 16'd110, 16'd7, 32'd99, {4{16'h4000}}, -1, 1'b0, STAT_GOOD},
            '{PFX_NONE, 16'd110, 16'd8, 32'd100, {16'h0, 16'h0, 16'h0, 16'd32685},
              -1, 1'b0, STAT_GOOD},
            '{PFX_NONE, 16'd110, 16'd9, 32'd101, {16'h0, 16'h0, 16'h0, 16'd32684},
              -1, 1'b0, STAT_GOOD},
            '{PFX_NONE, 16'd110, 16'd10, 32'd102, {16'h7FFF, 16'h0, 16'd32684, 16'h0},
              -1, 1'b0, STAT_GOOD},
            '{PFX_NONE, 16'd110, 16'd11, 32'd103, {16'h7FFF, 16'h0, 16'd32685, 16'h0},
              -1, 1'b0, STAT_GOOD},
            '{PFX_NONE, 16'd110, 16'd12, 32'd104, {16'h8001, 16'h0, 16'h0, 16'h0},
              -1, 1'b0, STAT_GOOD},
            '{PFX_NONE, 16'h0100, 16'd0, 32'd0, 64'd0, -1, 1'b1, STAT_BAD_LEN}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(0);
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_record(directed_recs[i]);

        framed_bytes = 0;
        while (framed_bytes < RANDOM_BYTES) begin
            set_phase(framed_bytes * 4 / RANDOM_BYTES);
            send_record(random_record());
        end
        in_valid <= 1'b0;

        while (status_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("random part: %0d framed bytes, %0d records in total", framed_bytes,
                 records_pushed);
        $display("statuses: good %0d, bad length %0d, bad ident %0d, bad norm %0d",
                 status_seen[STAT_GOOD], status_seen[STAT_BAD_LEN],
                 status_seen[STAT_BAD_ID], status_seen[STAT_BAD_NORM]);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ard_pkg.sv
hw/rtl/attitude_record_deframer.sv
tb/attitude_record_deframer_tb.sv
